// ===== rtl/button_encoder_event_decoder_assert.svh =====
// Assertion helpers for the button and encoder event decoder.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef BUTTON_ENCODER_EVENT_DECODER_ASSERT_SVH
`define BUTTON_ENCODER_EVENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BED_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("button_encoder_event_decoder: assertion failed");

// Next-cycle implication.
`define BED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("button_encoder_event_decoder: assertion failed");

`else

`define BED_ASSERT_IMP(lbl, ante, cons)
`define BED_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/bed_pkg.sv =====
`timescale 1ns / 1ps

package bed_pkg;

	localparam int PORT_W        = 16;
	localparam int TIME_W        = 32;
	localparam int HOLD_W        = 16;
	localparam int PIN_W         = 4;
	localparam int CODE_W        = 2;

	localparam int PORT_BITS_DEF     = 16;
	localparam int ENCODER_PIN_A_DEF = 1;

	localparam logic [PORT_W-1:0] INPUT_MASK_RST    = 16'h603F;
	localparam logic [HOLD_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

	// Configuration register indexes
	localparam logic REG_INPUT_MASK    = 1'b0;
	localparam logic REG_LONG_PRESS_MS = 1'b1;

	// Event codes
	localparam logic [CODE_W-1:0] CODE_DOWN = 2'd0;
	localparam logic [CODE_W-1:0] CODE_UP   = 2'd1;
	localparam logic [CODE_W-1:0] CODE_HOLD = 2'd2;
	localparam logic [CODE_W-1:0] CODE_TICK = 2'd3;

	// What the sequencer knows about the bit under scan
	typedef struct packed {
		logic changed;
		logic is_encoder;
		logic enc_differ;
		logic level;
		logic pending;
		logic pin_match;
	} bed_bit_t;

	// What the event unit decides for that bit
	typedef struct packed {
		logic              emit;
		logic [CODE_W-1:0] code;
		logic              clear_pending;
		logic              set_pending;
	} bed_act_t;

endpackage

// ===== rtl/button_encoder_event_decoder.sv =====
`timescale 1ns / 1ps

// Button and quadrature encoder event decoder. Each accepted snapshot of the
// input port is compared with the previous one under input_mask, and the
// bits below min(PORT_BITS, 16), changed or not, are scanned one per clock
// from bit 0 upward through a single event unit (classifier plus 32-bit
// hold-time subtract and compare). The scan holds while an event waits on
// out_ready, and in_ready is low for the whole scan. Each event is one
// output transfer of pin_index and event_code, and last_event marks the
// final event of a snapshot; a snapshot with no monitored change produces
// no transfer. Pins ENCODER_PIN_A and ENCODER_PIN_A+1 are the encoder, all
// other monitored pins are active-low buttons. Register 0 is input_mask,
// register 1 is long_press_ms; write them only while the block is idle.
`include "button_encoder_event_decoder_assert.svh"

module button_encoder_event_decoder
	import bed_pkg::*;
#(
	parameter int PORT_BITS     = PORT_BITS_DEF,
	parameter int ENCODER_PIN_A = ENCODER_PIN_A_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [PORT_W-1:0] cfg_data,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PORT_W-1:0] port_value,
	input  logic [TIME_W-1:0] now_ms,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIN_W-1:0]  pin_index,
	output logic [CODE_W-1:0] event_code,
	output logic              last_event
);

	localparam int ScanBits = (PORT_BITS < PORT_W) ? PORT_BITS : PORT_W;
	localparam int IdxW     = $clog2(ScanBits);
	localparam logic [PORT_W-1:0] ScanMask = PORT_W'((33'd1 << ScanBits) - 33'd1);
	localparam logic [PORT_W-1:0] EncMask  = PORT_W'(32'd3 << ENCODER_PIN_A);
	localparam logic [IdxW-1:0]   LastIdx  = IdxW'(ScanBits - 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [PORT_W-1:0] input_mask_q;
	logic [HOLD_W-1:0] long_press_ms_q;
	logic [PORT_W-1:0] prev_port_q;
	logic              pending_q;
	logic [PIN_W-1:0]  pressed_pin_q;
	logic [TIME_W-1:0] start_ms_q;

	logic [PORT_W-1:0] port_q;
	logic [TIME_W-1:0] now_q;
	logic [PORT_W-1:0] changed_q;
	logic [PORT_W-1:0] emit_q;
	logic              enc_differ_q;
	logic [IdxW-1:0]   idx_q;

	logic              out_valid_q;
	logic [PIN_W-1:0]  pin_index_q;
	logic [CODE_W-1:0] event_code_q;
	logic              last_event_q;

	logic [PORT_W-1:0] changed_in;
	logic              enc_differ_in;
	logic [PORT_W-1:0] idx_bit;
	logic [PIN_W-1:0]  idx_pin;
	bed_bit_t          bit_info;
	bed_act_t          act;
	logic              stall;
	logic              load_out;

	assign changed_in    = (prev_port_q ^ port_value) & input_mask_q & ScanMask;
	assign enc_differ_in = port_value[ENCODER_PIN_A] != port_value[ENCODER_PIN_A + 1];

	assign idx_bit = PORT_W'(1) << idx_q;
	assign idx_pin = PIN_W'(idx_q);

	always_comb begin
		bit_info.changed    = changed_q[idx_q];
		bit_info.is_encoder = (EncMask & idx_bit) != '0;
		bit_info.enc_differ = enc_differ_q;
		bit_info.level      = port_q[idx_q];
		bit_info.pending    = pending_q;
		bit_info.pin_match  = pressed_pin_q == idx_pin;
	end

	bed_event_unit u_event (
		.bit_info      (bit_info),
		.now_ms        (now_q),
		.start_ms      (start_ms_q),
		.long_press_ms (long_press_ms_q),
		.act           (act)
	);

	// Hold the scan while an event waits for the output register
	assign stall    = act.emit && out_valid_q && !out_ready;
	assign load_out = (state_q == ST_SCAN) && act.emit && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mask_q    <= INPUT_MASK_RST;
			long_press_ms_q <= LONG_PRESS_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_MASK:    input_mask_q    <= cfg_data;
				REG_LONG_PRESS_MS: long_press_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_port_q   <= '0;
			pending_q     <= 1'b0;
			pressed_pin_q <= '0;
			start_ms_q    <= '0;
			port_q        <= '0;
			now_q         <= '0;
			changed_q     <= '0;
			enc_differ_q  <= 1'b0;
			emit_q        <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
			pin_index_q   <= '0;
			event_code_q  <= '0;
			last_event_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_port_q  <= port_value;
						port_q       <= port_value;
						now_q        <= now_ms;
						changed_q    <= changed_in;
						enc_differ_q <= enc_differ_in;
						// drop encoder bits that give no step
						emit_q       <= changed_in & ~(EncMask & {PORT_W{!enc_differ_in}});
						idx_q        <= '0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (act.clear_pending) begin
							pending_q <= 1'b0;
						end
						if (act.set_pending) begin
							pending_q     <= 1'b1;
							pressed_pin_q <= idx_pin;
							start_ms_q    <= now_q;
						end
						if (act.emit) begin
							pin_index_q  <= idx_pin;
							event_code_q <= act.code;
							last_event_q <= (emit_q & ~idx_bit) == '0;
						end
						emit_q <= emit_q & ~idx_bit;
						if (idx_q == LastIdx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign pin_index  = pin_index_q;
	assign event_code = event_code_q;
	assign last_event = last_event_q;

	`BED_ASSERT_NXT(a_accept_starts_scan, in_valid && in_ready, !in_ready)
	`BED_ASSERT_IMP(a_idle_no_events_left, in_ready, emit_q == '0)
	`BED_ASSERT_IMP(a_pressed_pin_in_range, pending_q, int'(pressed_pin_q) < ScanBits)
	`BED_ASSERT_NXT(a_stall_holds_scan, (state_q == ST_SCAN) && stall, $stable(idx_q) && !in_ready)

endmodule

// ===== rtl/bed_event_unit.sv =====
`timescale 1ns / 1ps

module bed_event_unit
	import bed_pkg::*;
(
	input  bed_bit_t          bit_info,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [TIME_W-1:0] start_ms,
	input  logic [HOLD_W-1:0] long_press_ms,
	output bed_act_t          act
);

	logic [TIME_W-1:0] elapsed;
	logic              long_hit;

	// Wrapping hold time, compared against the threshold
	assign elapsed  = now_ms - start_ms;
	assign long_hit = elapsed > {{(TIME_W-HOLD_W){1'b0}}, long_press_ms};

	always_comb begin
		act = '0;
		if (bit_info.changed) begin
			if (bit_info.is_encoder) begin
				act.emit          = bit_info.enc_differ;
				act.code          = CODE_TICK;
				act.clear_pending = 1'b1;
			end else if (bit_info.level) begin
				act.emit          = 1'b1;
				act.code          = (bit_info.pending && bit_info.pin_match && long_hit) ?
					CODE_HOLD : CODE_UP;
				act.clear_pending = 1'b1;
			end else begin
				act.emit        = 1'b1;
				act.code        = CODE_DOWN;
				act.set_pending = 1'b1;
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import bed_pkg::*;

	localparam int ENC_A           = ENCODER_PIN_A_DEF;
	localparam int SCAN_W          = (PORT_BITS_DEF < 16) ? PORT_BITS_DEF : 16;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 84;
	localparam int DIR_ROWS        = 31;

	typedef struct packed {
		logic [PIN_W-1:0]  pin;
		logic [CODE_W-1:0] code;
		logic              last;
	} key_event_t;

	typedef struct packed {
		logic              is_cfg;
		logic              reg_sel;
		logic [PORT_W-1:0] value;
		logic [TIME_W-1:0] stamp;
		logic              typed;
		logic [PIN_W-1:0]  pin;
		logic [CODE_W-1:0] code;
	} step_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [PORT_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [PORT_W-1:0] port_value;
	logic [TIME_W-1:0] now_ms;
	logic              out_valid;
	logic              out_ready;
	logic [PIN_W-1:0]  pin_index;
	logic [CODE_W-1:0] event_code;
	logic              last_event;

	// scanner copy of the block state and registers
	logic [PORT_W-1:0] mdl_prev;
	logic [PORT_W-1:0] mdl_mask;
	logic [HOLD_W-1:0] mdl_hold;
	logic              mdl_pending;
	logic [PIN_W-1:0]  mdl_pin;
	logic [TIME_W-1:0] mdl_start;

	key_event_t        scan_events[$];
	key_event_t        due_events[$];
	int                bad_events = 0;
	int                sent_items = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	bit                hold_off_req = 1'b0;
	logic [PORT_W-1:0] cur_port = '0;
	logic [TIME_W-1:0] ms_clock = '0;

	step_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd0,          1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFE, 32'd100,        1'b1, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd1100,       1'b1, 4'd0,  CODE_UP},
		'{1'b0, REG_INPUT_MASK, 16'hFFFE, 32'd2000,       1'b1, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd3001,       1'b1, 4'd0,  CODE_HOLD},
		'{1'b0, REG_INPUT_MASK, 16'hFFFD, 32'd3100,       1'b1, 4'd1,  CODE_TICK},
		// encoder pins equal again: no event
		'{1'b0, REG_INPUT_MASK, 16'hFFF9, 32'd3110,       1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFB, 32'd3120,       1'b1, 4'd1,  CODE_TICK},
		'{1'b0, REG_INPUT_MASK, 16'hFFDB, 32'd4000,       1'b1, 4'd5,  CODE_DOWN},
		// encoder twitch without step still drops the press
		'{1'b0, REG_INPUT_MASK, 16'hFFDF, 32'd4010,       1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd9000,       1'b1, 4'd5,  CODE_UP},
		'{1'b0, REG_INPUT_MASK, 16'hFFF7, 32'd9100,       1'b1, 4'd3,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFF6, 32'd9200,       1'b1, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd20000,      1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hDFFF, 32'hFFFF_FF00,  1'b1, 4'd13, CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'h0000_0300,  1'b1, 4'd13, CODE_HOLD},
		'{1'b0, REG_INPUT_MASK, 16'h0000, 32'd400,        1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'h1F80, 32'd500,        1'b0, 4'd0,  CODE_DOWN},
		'{1'b1, REG_INPUT_MASK, 16'hFFFF, 32'd0,          1'b0, 4'd0,  CODE_DOWN},
		'{1'b1, REG_LONG_PRESS_MS, 16'h0000, 32'd0,       1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd600,        1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'h7FFF, 32'd700,        1'b1, 4'd15, CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd700,        1'b1, 4'd15, CODE_UP},
		'{1'b1, REG_LONG_PRESS_MS, 16'hFFFF, 32'd0,       1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'h7FFF, 32'd1000,       1'b1, 4'd15, CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd66535,      1'b1, 4'd15, CODE_UP},
		'{1'b0, REG_INPUT_MASK, 16'h7FFF, 32'd70000,      1'b1, 4'd15, CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd135536,     1'b1, 4'd15, CODE_HOLD},
		'{1'b1, REG_INPUT_MASK, 16'h0000, 32'd0,          1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'h0000, 32'd140000,     1'b0, 4'd0,  CODE_DOWN},
		'{1'b0, REG_INPUT_MASK, 16'hFFFF, 32'd140100,     1'b0, 4'd0,  CODE_DOWN}
	};

	button_encoder_event_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.port_value (port_value),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pin_index  (pin_index),
		.event_code (event_code),
		.last_event (last_event)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// walk the changed monitored bits, lowest first, into scan_events
	function automatic void scan_snapshot(input logic [PORT_W-1:0] pv,
			input logic [TIME_W-1:0] t);
		logic [PORT_W-1:0] diff;
		logic              enc_differ;
		key_event_t        ev;
		scan_events.delete();
		diff = (mdl_prev ^ pv) & mdl_mask;
		mdl_prev = pv;
		enc_differ = pv[ENC_A] != pv[ENC_A+1];
		for (int b = 0; b < SCAN_W; b++) begin
			if (diff[b]) begin
				ev.pin = 4'(b);
				ev.last = 1'b0;
				if (b == ENC_A || b == ENC_A + 1) begin
					mdl_pending = 1'b0;
					if (!enc_differ)
						continue;
					ev.code = CODE_TICK;
				end else if (pv[b]) begin
					if (mdl_pending && mdl_pin == 4'(b) && (t - mdl_start) > 32'(mdl_hold))
						ev.code = CODE_HOLD;
					else
						ev.code = CODE_UP;
					mdl_pending = 1'b0;
				end else begin
					mdl_pending = 1'b1;
					mdl_pin = 4'(b);
					mdl_start = t;
					ev.code = CODE_DOWN;
				end
				scan_events.push_back(ev);
			end
		end
		if (scan_events.size() != 0)
			scan_events[scan_events.size()-1].last = 1'b1;
	endfunction

	// offer one snapshot; valid stays up from the previous transfer unless we idle
	task automatic send_snapshot(input logic [PORT_W-1:0] pv, input logic [TIME_W-1:0] t,
			input logic typed, input key_event_t known);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		port_value <= pv;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
		cur_port = pv;
		scan_snapshot(pv, t);
		sent_items++;
		if (typed)
			due_events.push_back(known);
		else
			foreach (scan_events[k])
				due_events.push_back(scan_events[k]);
	endtask

	// drop valid, wait for every event, then for a scan with no events to finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [PORT_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == REG_INPUT_MASK)
			mdl_mask = val;
		else
			mdl_hold = val;
	endtask

	task automatic random_burst();
		int                kind;
		int                pin;
		int                steps;
		bit                dir;
		logic [PORT_W-1:0] bit_sel;
		logic [PORT_W-1:0] p;
		logic [TIME_W-1:0] t0;
		kind = $urandom_range(0, 9);
		ms_clock += $urandom_range(1, 300);
		if ($urandom_range(0, 19) == 0)
			ms_clock = $urandom();
		case (kind)
			0, 1, 2, 3, 4, 9: begin
				pin = $urandom_range(0, 15);
				bit_sel = 16'h1 << pin;
				if ((cur_port & bit_sel) == '0)
					send_snapshot(cur_port | bit_sel, ms_clock, 1'b0, '0);
				t0 = ms_clock;
				send_snapshot(cur_port & ~bit_sel, t0, 1'b0, '0);
				// interfere with the press: another pin, or an encoder twitch
				if (kind == 4)
					send_snapshot(cur_port ^ (16'h1 << $urandom_range(0, 15)), t0 + 32'd5,
						1'b0, '0);
				else if (kind == 9)
					send_snapshot(cur_port ^ (16'h1 << ($urandom_range(0, 1) + ENC_A)),
						t0 + 32'd5, 1'b0, '0);
				if ($urandom_range(0, 3) == 0)
					ms_clock = t0 + 32'($urandom_range(0, 2 * int'(mdl_hold) + 10));
				else
					ms_clock = t0 + 32'(mdl_hold) + 32'($urandom_range(0, 4)) - 32'd2;
				send_snapshot(cur_port | bit_sel, ms_clock, 1'b0, '0);
			end
			5, 6: begin
				steps = $urandom_range(2, 6);
				dir = $urandom_range(0, 1);
				// hold a button across the turn so the encoder cancels it
				if (kind == 6)
					send_snapshot(cur_port & ~16'h0001, ms_clock, 1'b0, '0);
				repeat (steps) begin
					p = cur_port;
					if ((p[ENC_A] == p[ENC_A+1]) ^ dir)
						p[ENC_A] = ~p[ENC_A];
					else
						p[ENC_A+1] = ~p[ENC_A+1];
					ms_clock += $urandom_range(1, 20);
					send_snapshot(p, ms_clock, 1'b0, '0);
				end
				if (kind == 6)
					send_snapshot(cur_port | 16'h0001, ms_clock + 32'(mdl_hold) + 32'd1,
						1'b0, '0);
			end
			7:
				send_snapshot(16'($urandom()), $urandom(), 1'b0, '0);
			default:
				send_snapshot(cur_port ^ (16'h1 << $urandom_range(0, 15))
					^ (16'h1 << $urandom_range(0, 15)), ms_clock, 1'b0, '0);
		endcase
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_events
		key_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_events.size() == 0) begin
				$error("unexpected transfer: pin_index %0d event_code %0d last_event %0d",
					pin_index, event_code, last_event);
				bad_events++;
			end else begin
				want = due_events.pop_front();
				if (pin_index !== want.pin) begin
					$error("pin_index: expected %0d, actual %0d", want.pin, pin_index);
					bad_events++;
				end
				if (event_code !== want.code) begin
					$error("event_code: expected %0d, actual %0d", want.code, event_code);
					bad_events++;
				end
				if (last_event !== want.last) begin
					$error("last_event: expected %0d, actual %0d", want.last, last_event);
					bad_events++;
				end
			end
		end
	end

	initial begin : stimulus
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INPUT_MASK;
		cfg_data = '0;
		in_valid = 1'b0;
		port_value = '0;
		now_ms = '0;
		mdl_prev = '0;
		mdl_mask = INPUT_MASK_RST;
		mdl_hold = LONG_PRESS_MS_RST;
		mdl_pending = 1'b0;
		mdl_pin = '0;
		mdl_start = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 48;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg)
				write_reg(dir_rows[r].reg_sel, dir_rows[r].value);
			else
				send_snapshot(dir_rows[r].value, dir_rows[r].stamp, dir_rows[r].typed,
					'{dir_rows[r].pin, dir_rows[r].code, 1'b1});
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_INPUT_MASK, INPUT_MASK_RST);
					write_reg(REG_LONG_PRESS_MS, LONG_PRESS_MS_RST);
				end
				1: begin
					write_reg(REG_INPUT_MASK, 16'hFFFF);
					write_reg(REG_LONG_PRESS_MS, 16'($urandom_range(0, 200)));
					send_idle_pct = 48;
					recv_idle_pct = 24;
					hold_off_req = 1'b1;
				end
				default: begin
					write_reg(REG_INPUT_MASK, 16'($urandom()) | 16'h8001);
					write_reg(REG_LONG_PRESS_MS, 16'($urandom()));
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = sent_items + ITEMS_PER_PHASE;
			while (sent_items < target)
				random_burst();
		end

		settle();
		if (bad_events == 0 && due_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
